FILE: hw/rtl/euclidean_distance_stream_assert.svh
// Assertion macros for the Euclidean distance block.
`ifndef EUCLIDEAN_DISTANCE_STREAM_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_STREAM_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define EDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define EDS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/eds_pkg.sv
// Types and constants of the Euclidean distance block.
package eds_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned SumW   = 45;
  localparam int unsigned DistW  = 23;
  localparam int unsigned RadW   = 2 * DistW;
  localparam int unsigned RemW   = DistW + 3;
  localparam int unsigned CntW   = $clog2(DistW);

  localparam logic [SumW-1:0]  SumMax  = {SumW{1'b1}};
  localparam logic [DistW-1:0] SatRoot = DistW'(5931641);

  typedef struct packed {
    logic [CoordW-1:0] coord_a;
    logic [CoordW-1:0] coord_b;
    logic              last_coord;
  } eds_in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             saturated;
  } eds_out_t;

endpackage

FILE: hw/rtl/euclidean_distance_stream.sv
// Streaming Euclidean distance: accumulate squared differences, root on last.
//
// Each transaction carries one coordinate pair. A pair that is not marked last
// has its difference captured, then squared, then accumulated into the 45-bit
// saturating sum. A pair marked last goes through those steps, then 23 steps
// of a restoring square root that shares one 26-bit subtractor, then a load of
// the output register. That load waits while an earlier result is
// still stalled in the output register. The input is stalled while an item is
// in work; a finished result waits in the output register while the next pair
// is taken.
module euclidean_distance_stream (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  eds_pkg::eds_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output eds_pkg::eds_out_t out_data_o
);
  import eds_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StAcc  = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StPush = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CoordW-1:0] diff_q, diff_d;
  logic              last_q, last_d;
  logic [SqW-1:0]    sq_q, sq_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic              clip_q, clip_d;
  logic              sat_q, sat_d;
  logic [RadW-1:0]   rad_q, rad_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [DistW-1:0]  root_q, root_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  eds_out_t          out_q, out_d;

  logic              in_fire;
  logic [SumW:0]     sum_add;
  logic              sum_ovf;
  logic [SumW-1:0]   sum_next;
  logic [RemW-1:0]   rem_sh;
  logic [RemW-1:0]   trial;
  logic [RemW:0]     rem_sub;
  logic              ge;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign sum_add  = {1'b0, sum_q} + {{(SumW + 1 - SqW){1'b0}}, sq_q};
  assign sum_ovf  = sum_add[SumW];
  assign sum_next = sum_ovf ? SumMax : sum_add[SumW-1:0];
  assign rem_sh   = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial    = {1'b0, root_q, 2'b01};
  assign rem_sub  = {1'b0, rem_sh} - {1'b0, trial};
  assign ge       = !rem_sub[RemW];

  always_comb begin
    state_d     = state_q;
    diff_d      = diff_q;
    last_d      = last_q;
    sq_d        = sq_q;
    sum_d       = sum_q;
    clip_d      = clip_q;
    sat_d       = sat_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          diff_d  = (in_data_i.coord_a >= in_data_i.coord_b) ?
                    in_data_i.coord_a - in_data_i.coord_b :
                    in_data_i.coord_b - in_data_i.coord_a;
          last_d  = in_data_i.last_coord;
          state_d = StMul;
        end
      end
      StMul: begin
        sq_d    = diff_q * diff_q;
        state_d = StAcc;
      end
      StAcc: begin
        if (last_q) begin
          rad_d   = {{(RadW - SumW){1'b0}}, sum_next};
          sat_d   = clip_q || sum_ovf;
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = CntW'(DistW - 1);
          sum_d   = '0;
          clip_d  = 1'b0;
          state_d = StRoot;
        end else begin
          sum_d   = sum_next;
          clip_d  = clip_q || sum_ovf;
          state_d = StIdle;
        end
      end
      StRoot: begin
        rem_d  = ge ? rem_sub[RemW-1:0] : rem_sh;
        root_d = {root_q[DistW-2:0], ge};
        rad_d  = {rad_q[RadW-3:0], 2'b00};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.distance  = root_q;
          out_d.saturated = sat_q;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sum_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    last_q <= last_d;
    sq_q   <= sq_d;
    sat_q  <= sat_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "euclidean_distance_stream_assert.svh"

  `EDS_ASSERT(a_busy_after_accept, in_fire |=> in_stall_o, "input not stalled after transaction")
  `EDS_ASSERT_IMPL(a_clip_sticks, clip_q, sum_q == SumMax, "clip flag set but sum not at maximum")
  `EDS_ASSERT_IMPL(a_sat_root, out_valid_o && out_data_o.saturated,
                   out_data_o.distance == SatRoot, "saturated result with wrong distance")
  `EDS_ASSERT_IMPL(a_root_count, state_q == StRoot, cnt_q <= CntW'(DistW - 1),
                   "root step count out of range")

endmodule
